/* hdl/cte_pkg.sv */
// Shared constants, types and helpers for the CLUT texel expander.
// No dependencies; every other file in hdl/ takes names from here.
package cte_pkg;

   // Field widths of the channels
   localparam int OPCODE_W    = 2;
   localparam int ENTRY_W     = 8;
   localparam int WORD_W      = 16;
   localparam int CHAN_W      = 8;
   localparam int MODE_W      = 2;
   localparam int COUNT_W     = 9;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;

   // Palette store default depth
   localparam int PALETTE_DEPTH_DEFAULT = 256;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Opcodes of the request word
   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE = 2'd0,
      OP_PIXEL = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   // Pixel modes
   localparam logic [MODE_W-1:0] MODE_4BPP   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_8BPP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd2;

   // Register indexes of the CSR port
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_MODE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_PALETTE_COUNT = 1'b1;

   // Channel constants
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CHAN_W-1:0] CHAN_ZERO    = 8'h00;

   // Classified commands carried by the queue
   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_PIXEL,
      CMD_CLEAR
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic                nibble;
      logic                direct;
      logic [1:0]          last_k;
      logic [ENTRY_W-1:0]  entry_index;
      logic [WORD_W-1:0]   data_word;
   } item_type;

   // Widen a 5-bit channel to 8 bits by replicating its top bits
   function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

endpackage

/* hdl/cte_if.sv */
// Handshake channels of the CLUT texel expander: request, response and CSR write.
// Depends on cte_pkg for field widths.
interface cte_req_if;
   logic                           valid;
   logic                           ready;
   logic [cte_pkg::OPCODE_W-1:0]   opcode;
   logic [cte_pkg::ENTRY_W-1:0]    entry_index;
   logic [cte_pkg::WORD_W-1:0]     data_word;

   modport source (output valid, opcode, entry_index, data_word, input ready);
   modport sink   (input valid, opcode, entry_index, data_word, output ready);
endinterface

interface cte_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cte_pkg::CHAN_W-1:0]    red;
   logic [cte_pkg::CHAN_W-1:0]    green;
   logic [cte_pkg::CHAN_W-1:0]    blue;
   logic [cte_pkg::CHAN_W-1:0]    alpha;
   logic                          transparent_seen;
   logic                          last_texel;

   modport source (output valid, red, green, blue, alpha, transparent_seen, last_texel,
                   input ready);
   modport sink   (input valid, red, green, blue, alpha, transparent_seen, last_texel,
                   output ready);
endinterface

interface cte_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cte_pkg::CSR_INDEX_W-1:0]  index;
   logic [cte_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/cte_front.sv */
// Front end: CSR registers, request acceptance and command classification.
// Depends on cte_pkg and the channel interfaces in cte_if.sv.
module cte_front #(
   parameter int PALETTE_DEPTH = cte_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   cte_req_if.sink                       req_chan,
   cte_csr_if.sink                       csr_chan,
   output logic                          push_valid,
   output cte_pkg::item_type             push_item,
   input  logic                          push_ready,
   output logic [cte_pkg::COUNT_W-1:0]   palette_count
);

   logic [cte_pkg::MODE_W-1:0]   mode_ff;
   logic [cte_pkg::MODE_W-1:0]   mode_in;
   logic [cte_pkg::COUNT_W-1:0]  count_ff;
   logic [cte_pkg::COUNT_W-1:0]  count_in;
   logic [cte_pkg::COUNT_W-1:0]  count_sat;

   // CSR writes are always taken
   assign csr_chan.ready = 1'b1;

   // Saturate the palette count to the store depth
   always_comb begin
      if (csr_chan.data > cte_pkg::COUNT_W'(PALETTE_DEPTH)) begin
         count_sat = cte_pkg::COUNT_W'(PALETTE_DEPTH);
      end else begin
         count_sat = csr_chan.data;
      end
   end

   // Decode the register write
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            cte_pkg::REG_PIXEL_MODE: begin
               mode_in = csr_chan.data[cte_pkg::MODE_W-1:0];
            end
            cte_pkg::REG_PALETTE_COUNT: begin
               count_in = count_sat;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cte_pkg::MODE_DIRECT;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   assign palette_count = count_ff;

   // Stall the request side only when the queue is full
   assign req_chan.ready = push_ready;

   // Classify the word; unknown opcodes are taken and dropped
   always_comb begin
      push_item.entry_index = req_chan.entry_index;
      push_item.data_word   = req_chan.data_word;
      push_item.nibble      = 1'b0;
      push_item.direct      = 1'b0;
      push_item.last_k      = 2'd0;
      push_item.cmd         = cte_pkg::CMD_WRITE;
      push_valid            = 1'b0;
      case (cte_pkg::opcode_type'(req_chan.opcode))
         cte_pkg::OP_WRITE: begin
            push_item.cmd = cte_pkg::CMD_WRITE;
            push_valid    = req_chan.valid;
         end
         cte_pkg::OP_PIXEL: begin
            push_item.cmd = cte_pkg::CMD_PIXEL;
            push_valid    = req_chan.valid;
         end
         cte_pkg::OP_CLEAR: begin
            push_item.cmd = cte_pkg::CMD_CLEAR;
            push_valid    = req_chan.valid;
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
      // Texels per halfword follow the pixel mode
      case (mode_ff)
         cte_pkg::MODE_4BPP: begin
            push_item.nibble = 1'b1;
            push_item.last_k = 2'd3;
         end
         cte_pkg::MODE_8BPP: begin
            push_item.last_k = 2'd1;
         end
         default: begin
            push_item.direct = 1'b1;
         end
      endcase
   end

endmodule

/* hdl/cte_queue.sv */
// Short command queue decoupling the front end from the texel back end.
// Depends on cte_pkg for the item type and queue depth.
module cte_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  cte_pkg::item_type   push_item,
   output logic                push_ready,
   output logic                pop_valid,
   output cte_pkg::item_type   pop_item,
   input  logic                pop_ready
);

   cte_pkg::item_type                entries_ff [cte_pkg::QUEUE_DEPTH];
   logic [cte_pkg::QUEUE_AW-1:0]     wr_ptr_ff;
   logic [cte_pkg::QUEUE_AW-1:0]     wr_ptr_in;
   logic [cte_pkg::QUEUE_AW-1:0]     rd_ptr_ff;
   logic [cte_pkg::QUEUE_AW-1:0]     rd_ptr_in;
   logic [cte_pkg::QUEUE_AW:0]       fill_ff;
   logic [cte_pkg::QUEUE_AW:0]       fill_in;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = (fill_ff != (cte_pkg::QUEUE_AW+1)'(cte_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold the word in its slot
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/cte_back.sv */
// Back end: palette store, per-texel issue, colour expansion and response register.
// Depends on cte_pkg and the response interface in cte_if.sv.
module cte_back #(
   parameter int PALETTE_DEPTH = cte_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  cte_pkg::item_type             head_item,
   output logic                          head_pop,
   input  logic [cte_pkg::COUNT_W-1:0]   palette_count,
   cte_rsp_if.source                     rsp_chan
);

   localparam int ADDR_W = $clog2(PALETTE_DEPTH);

   // Palette store and its registered read port
   logic [cte_pkg::WORD_W-1:0]  palette_ff [PALETTE_DEPTH];
   logic [cte_pkg::WORD_W-1:0]  rd_data_ff;

   // Issue stage
   logic [1:0]                  k_ff;
   logic [1:0]                  k_in;
   logic [cte_pkg::ENTRY_W-1:0] idx;
   logic                        is_last;
   logic                        issue_go;
   logic                        wr_en;
   logic                        rd_en;
   logic                        s1_load;

   // Lookup stage
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic                        s1_clear_ff;
   logic                        s1_direct_ff;
   logic                        s1_in_range_ff;
   logic                        s1_last_ff;
   logic [cte_pkg::WORD_W-1:0]  s1_word_ff;
   logic                        s1_go;
   logic                        s1_ready;
   logic [cte_pkg::WORD_W-1:0]  colour;

   // Response stage and sticky flag
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        out_free;
   logic                        flag_ff;
   logic                        flag_in;
   logic [cte_pkg::CHAN_W-1:0]  red_ff;
   logic [cte_pkg::CHAN_W-1:0]  green_ff;
   logic [cte_pkg::CHAN_W-1:0]  blue_ff;
   logic [cte_pkg::CHAN_W-1:0]  alpha_ff;
   logic                        seen_ff;
   logic                        last_ff;

   // Pick the palette index of the current texel
   always_comb begin
      if (head_item.nibble) begin
         idx = {4'd0, head_item.data_word[{k_ff, 2'b00} +: 4]};
      end else if (k_ff[0]) begin
         idx = head_item.data_word[15:8];
      end else begin
         idx = head_item.data_word[7:0];
      end
   end

   assign is_last = (k_ff == head_item.last_k);

   // Issue one texel, one write or one clear a cycle; texels and clears wait while the lookup stage is held
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go    = s1_valid_ff && (s1_clear_ff || out_free);
   assign s1_ready = !s1_valid_ff || s1_go;
   assign issue_go = head_valid && ((head_item.cmd == cte_pkg::CMD_WRITE) || s1_ready);
   assign head_pop = issue_go && ((head_item.cmd != cte_pkg::CMD_PIXEL) || is_last);
   assign s1_load  = issue_go && (head_item.cmd != cte_pkg::CMD_WRITE);
   assign wr_en    = issue_go && (head_item.cmd == cte_pkg::CMD_WRITE) &&
                     ({1'b0, head_item.entry_index} < cte_pkg::COUNT_W'(PALETTE_DEPTH));
   assign rd_en    = issue_go && (head_item.cmd == cte_pkg::CMD_PIXEL) && !head_item.direct;

   always_comb begin
      k_in = k_ff;
      if (head_pop) begin
         k_in = 2'd0;
      end else if (issue_go && (head_item.cmd == cte_pkg::CMD_PIXEL)) begin
         k_in = k_ff + 2'd1;
      end
   end

   // Write and read the palette
   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_ff[head_item.entry_index[ADDR_W-1:0]] <= head_item.data_word;
      end
      if (rd_en) begin
         rd_data_ff <= palette_ff[idx[ADDR_W-1:0]];
      end
   end

   // Load the lookup stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_clear_ff    <= (head_item.cmd == cte_pkg::CMD_CLEAR);
         s1_direct_ff   <= head_item.direct;
         s1_in_range_ff <= ({1'b0, idx} < palette_count);
         s1_last_ff     <= is_last;
         s1_word_ff     <= head_item.data_word;
      end
   end

   // Resolve the raw colour; out-of-range indices give zero
   always_comb begin
      if (s1_direct_ff) begin
         colour = s1_word_ff;
      end else if (s1_in_range_ff) begin
         colour = rd_data_ff;
      end else begin
         colour = '0;
      end
   end

   // Update the sticky flag in texel order
   always_comb begin
      flag_in = flag_ff;
      if (s1_go) begin
         if (s1_clear_ff) begin
            flag_in = 1'b0;
         end else if (colour == '0) begin
            flag_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && !s1_clear_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= 2'd0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flag_ff      <= 1'b0;
      end else begin
         k_ff         <= k_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flag_ff      <= flag_in;
      end
   end

   // Expand the texel into the response register
   always_ff @(posedge clock) begin
      if (s1_go && !s1_clear_ff) begin
         if (colour == '0) begin
            red_ff   <= cte_pkg::CHAN_ZERO;
            green_ff <= cte_pkg::CHAN_ZERO;
            blue_ff  <= cte_pkg::CHAN_ZERO;
            alpha_ff <= cte_pkg::CHAN_ZERO;
         end else begin
            red_ff   <= cte_pkg::widen5(colour[4:0]);
            green_ff <= cte_pkg::widen5(colour[9:5]);
            blue_ff  <= cte_pkg::widen5(colour[14:10]);
            alpha_ff <= cte_pkg::ALPHA_OPAQUE;
         end
         seen_ff <= flag_in;
         last_ff <= s1_last_ff;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.red              = red_ff;
   assign rsp_chan.green            = green_ff;
   assign rsp_chan.blue             = blue_ff;
   assign rsp_chan.alpha            = alpha_ff;
   assign rsp_chan.transparent_seen = seen_ff;
   assign rsp_chan.last_texel       = last_ff;

endmodule

/* hdl/clut_texel_expander.sv */
// CLUT texel expander: a pixel word passes the queue, lookup stage and response register.
// Throughput is one texel per cycle while responses are taken, set by the single palette
// read port; a pixel word gives 4 texels in 4bpp, 2 in 8bpp and 1 in direct mode.
// Reset: synchronous, active high; mode is direct colour, count 0, flag clear, queue
// empty. The palette store is not cleared and holds nothing valid until written.
module clut_texel_expander #(
   parameter int PALETTE_DEPTH = cte_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cte_req_if.sink     req_chan,
   cte_rsp_if.source   rsp_chan,
   cte_csr_if.sink     csr_chan
);

   logic                          push_valid;
   logic                          push_ready;
   cte_pkg::item_type             push_item;
   logic                          head_valid;
   logic                          head_pop;
   cte_pkg::item_type             head_item;
   logic [cte_pkg::COUNT_W-1:0]   palette_count;

   // Accept and classify words
   cte_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .csr_chan      (csr_chan),
      .push_valid    (push_valid),
      .push_item     (push_item),
      .push_ready    (push_ready),
      .palette_count (palette_count)
   );

   // Buffer commands between the two halves
   cte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (head_valid),
      .pop_item   (head_item),
      .pop_ready  (head_pop)
   );

   // Expand texels
   cte_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_pop      (head_pop),
      .palette_count (palette_count),
      .rsp_chan      (rsp_chan)
   );

endmodule

/* dv/clut_texel_expander_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for clut_texel_expander: palette loads, 4bpp/8bpp/direct expansion,
// transparency flag. Needs cte_pkg, the channel interfaces of cte_if and the block itself.
module clut_texel_expander_tb;
   import cte_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;
   localparam int                  DEPTH       = PALETTE_DEPTH_DEFAULT;
   localparam int                  DRAIN_CYCLES = 24;
   localparam int                  CYCLE_LIMIT  = 400000;
   localparam int                  NUM_PHASES   = 10;
   localparam int                  CALM_PHASE   = 3;

   // Register settings per phase; a count of -1 means a random count
   localparam int PHASE_MODE  [NUM_PHASES] = '{0, 1, 0, 1, 3, 1, 0, 2, 1, 0};
   localparam int PHASE_COUNT [NUM_PHASES] = '{16, 256, 0, 511, -1, 1, 5, 300, 200, 256};
   localparam int PHASE_ITEMS [NUM_PHASES] = '{28, 28, 18, 28, 24, 24, 28, 24, 28, 30};

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [ENTRY_W-1:0]  entry_index;
      logic [WORD_W-1:0]   data_word;
   } halfword_cmd_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              transparent_seen;
      logic              last_texel;
   } texel_type;

   logic clock;
   logic reset;

   cte_req_if req_chan ();
   cte_rsp_if rsp_chan ();
   cte_csr_if csr_chan ();

   clut_texel_expander u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Commands waiting to be driven, texels waiting to come out
   halfword_cmd_type pending_cmds [$];
   texel_type        awaited_texels [$];

   // Shadow of the block's state, advanced on each accepted word
   logic [WORD_W-1:0]  shadow_palette [DEPTH];
   logic               shadow_flag;
   logic [MODE_W-1:0]  shadow_mode;
   logic [COUNT_W-1:0] shadow_count;

   // Palette entries the stimulus has loaded so far
   bit entry_loaded [DEPTH];

   bit no_stall;
   int cycle_count;
   int mismatches;
   int texels_checked;
   int pixels_sent, writes_sent, clears_sent, ignored_sent, settings_used;

   // Clock and initial values of every channel input
   initial begin
      clock                = 1'b0;
      no_stall             = 1'b0;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = '0;
      req_chan.entry_index = '0;
      req_chan.data_word   = '0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = '0;
      csr_chan.data        = '0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Predicted texel for one raw colour; a zero colour is transparent and sets the flag
   task automatic push_texel(input logic [WORD_W-1:0] colour, input logic is_last);
      texel_type t;
      if (colour == '0) begin
         shadow_flag = 1'b1;
         t.red   = '0;
         t.green = '0;
         t.blue  = '0;
         t.alpha = '0;
      end else begin
         t.red   = {colour[4:0], colour[4:2]};
         t.green = {colour[9:5], colour[9:7]};
         t.blue  = {colour[14:10], colour[14:12]};
         t.alpha = ALPHA_OPAQUE;
      end
      t.transparent_seen = shadow_flag;
      t.last_texel       = is_last;
      awaited_texels.push_back(t);
   endtask

   // Palette read; indices at or past the saturated count read as zero
   function automatic logic [WORD_W-1:0] palette_colour(input int idx);
      int limit;
      limit = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
      return (idx < limit) ? shadow_palette[idx] : '0;
   endfunction

   task automatic expand_halfword(input logic [WORD_W-1:0] hw);
      int k;
      case (shadow_mode)
         MODE_4BPP: begin
            for (k = 0; k < 4; k++)
               push_texel(palette_colour(int'(hw[4*k +: 4])), k == 3);
         end
         MODE_8BPP: begin
            push_texel(palette_colour(int'(hw[7:0])), 1'b0);
            push_texel(palette_colour(int'(hw[15:8])), 1'b1);
         end
         default: push_texel(hw, 1'b1);
      endcase
   endtask

   task automatic apply_cmd(input halfword_cmd_type c);
      case (c.opcode)
         OP_WRITE: begin
            shadow_palette[c.entry_index] = c.data_word;
            writes_sent++;
         end
         OP_CLEAR: begin
            shadow_flag = 1'b0;
            clears_sent++;
         end
         OP_PIXEL: begin
            expand_halfword(c.data_word);
            pixels_sent++;
         end
         default: ignored_sent++;
      endcase
   endtask

   // Request driver: hold the word until taken, idle at random
   always @(posedge clock) begin
      halfword_cmd_type c;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            c.opcode      = req_chan.opcode;
            c.entry_index = req_chan.entry_index;
            c.data_word   = req_chan.data_word;
            apply_cmd(c);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_cmds.size() != 0 && (no_stall || $urandom_range(99) >= 13)) begin
               c = pending_cmds.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.opcode      <= c.opcode;
               req_chan.entry_index <= c.entry_index;
               req_chan.data_word   <= c.data_word;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input logic [CHAN_W-1:0] want,
                                       input logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Texel monitor: compare each taken texel with the oldest prediction
   always @(posedge clock) begin
      texel_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_texels.size() == 0) begin
               $error("texel with nothing expected: r %0d g %0d b %0d a %0d",
                      rsp_chan.red, rsp_chan.green, rsp_chan.blue, rsp_chan.alpha);
               mismatches++;
            end else begin
               want = awaited_texels.pop_front();
               check_field("red", want.red, rsp_chan.red);
               check_field("green", want.green, rsp_chan.green);
               check_field("blue", want.blue, rsp_chan.blue);
               check_field("alpha", want.alpha, rsp_chan.alpha);
               check_field("transparent_seen", 8'(want.transparent_seen),
                           8'(rsp_chan.transparent_seen));
               check_field("last_texel", 8'(want.last_texel), 8'(rsp_chan.last_texel));
               texels_checked++;
            end
         end
         rsp_chan.ready <= no_stall || ($urandom_range(99) >= 13);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words queued, %0d texels outstanding",
                  cycle_count, pending_cmds.size(), awaited_texels.size());
         $display("status: fail");
         $finish;
      end
   end

   // Register write; updates the shadow once the word is taken
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      if (idx == REG_PIXEL_MODE)
         shadow_mode = value[MODE_W-1:0];
      else
         shadow_count = value[COUNT_W-1:0];
   endtask

   // Wait until every word is taken and every texel seen, then let the pipe settle
   task automatic wait_drained();
      @(negedge clock);
      while (pending_cmds.size() != 0 || req_chan.valid || awaited_texels.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [ENTRY_W-1:0] entry,
                            input logic [WORD_W-1:0] data);
      halfword_cmd_type c;
      c.opcode      = op;
      c.entry_index = entry;
      c.data_word   = data;
      pending_cmds.push_back(c);
   endtask

   function automatic logic [WORD_W-1:0] random_colour();
      return ($urandom_range(9) == 0) ? '0 : WORD_W'($urandom);
   endfunction

   // Load a palette slot first if a pixel would read it while still empty
   task automatic load_if_needed(input int idx, input int eff);
      if (idx < eff && !entry_loaded[idx]) begin
         queue_cmd(OP_WRITE, ENTRY_W'(idx), random_colour());
         entry_loaded[idx] = 1'b1;
      end
   endtask

   task automatic queue_pixel(input logic [WORD_W-1:0] hw, input logic [MODE_W-1:0] mode,
                              input int eff);
      int k;
      if (mode == MODE_4BPP) begin
         for (k = 0; k < 4; k++)
            load_if_needed(int'(hw[4*k +: 4]), eff);
      end else if (mode == MODE_8BPP) begin
         load_if_needed(int'(hw[7:0]), eff);
         load_if_needed(int'(hw[15:8]), eff);
      end
      queue_cmd(OP_PIXEL, ENTRY_W'($urandom), hw);
   endtask

   // One random word; mostly pixels whose indices favour the valid part of the palette
   task automatic queue_random(input logic [MODE_W-1:0] mode, input int eff,
                               output bit counts);
      int roll, span, k;
      logic [WORD_W-1:0] hw;
      roll   = $urandom_range(99);
      counts = 1'b1;
      if (roll < 3) begin
         queue_cmd(OP_UNUSED, ENTRY_W'($urandom), WORD_W'($urandom));
         counts = 1'b0;
      end else if (roll < 9) begin
         queue_cmd(OP_CLEAR, ENTRY_W'($urandom), WORD_W'($urandom));
      end else if (roll < 24) begin
         k = $urandom_range(DEPTH - 1);
         queue_cmd(OP_WRITE, ENTRY_W'(k), random_colour());
         entry_loaded[k] = 1'b1;
      end else begin
         hw = WORD_W'($urandom);
         if (mode == MODE_4BPP) begin
            span = (eff > 16) ? 16 : eff;
            for (k = 0; k < 4; k++)
               if (span > 0 && $urandom_range(3) != 0)
                  hw[4*k +: 4] = 4'($urandom_range(span - 1));
         end else if (mode == MODE_8BPP) begin
            for (k = 0; k < 2; k++)
               if (eff > 0 && $urandom_range(3) != 0)
                  hw[8*k +: 8] = 8'($urandom_range(eff - 1));
         end else begin
            roll = $urandom_range(19);
            if (roll == 0)
               hw = '0;
            else if (roll == 1)
               hw = 16'h8000;
         end
         queue_pixel(hw, mode, eff);
      end
   endtask

   // Stimulus
   initial begin
      logic [MODE_W-1:0] mode;
      int count, eff, lo, hi, done, p;
      bit counts;

      for (int i = 0; i < DEPTH; i++)
         shadow_palette[i] = '0;
      shadow_flag  = 1'b0;
      shadow_mode  = MODE_DIRECT;
      shadow_count = '0;

      wait (!reset);
      @(posedge clock);

      // Directed words under the reset settings (direct colour, empty palette)
      queue_cmd(OP_PIXEL, 8'h00, 16'h0000);
      queue_cmd(OP_PIXEL, 8'hFF, 16'hFFFF);
      queue_cmd(OP_CLEAR, 8'h00, 16'h0000);
      queue_cmd(OP_PIXEL, 8'h00, 16'h8000);
      queue_cmd(OP_PIXEL, 8'h00, 16'h7FFF);
      queue_cmd(OP_PIXEL, 8'h00, 16'h001F);
      queue_cmd(OP_PIXEL, 8'h00, 16'h03E0);
      queue_cmd(OP_PIXEL, 8'h00, 16'h7C00);
      queue_cmd(OP_PIXEL, 8'h00, 16'h0421);
      queue_cmd(OP_UNUSED, 8'hFF, 16'hFFFF);
      queue_cmd(OP_WRITE, 8'h00, 16'h7FFF);
      queue_cmd(OP_WRITE, 8'hFF, 16'h8001);
      entry_loaded[0]   = 1'b1;
      entry_loaded[255] = 1'b1;
      queue_cmd(OP_PIXEL, 8'h00, 16'h0000);
      queue_cmd(OP_CLEAR, 8'hFF, 16'hFFFF);
      queue_cmd(OP_PIXEL, 8'h00, 16'h0001);
      wait_drained();

      // Phases of register settings, each opened by boundary words
      for (p = 0; p < NUM_PHASES; p++) begin
         mode  = MODE_W'(PHASE_MODE[p]);
         count = (PHASE_COUNT[p] < 0) ? $urandom_range(511) : PHASE_COUNT[p];
         eff   = (count > DEPTH) ? DEPTH : count;
         write_reg(REG_PIXEL_MODE, CSR_DATA_W'(mode));
         write_reg(REG_PALETTE_COUNT, CSR_DATA_W'(count));
         settings_used++;
         no_stall = (p == CALM_PHASE);

         lo = (eff == 0) ? 0 : eff - 1;
         hi = (eff > 255) ? 255 : eff;
         if (mode == MODE_4BPP) begin
            lo = (lo > 15) ? 15 : lo;
            hi = (hi > 15) ? 15 : hi;
            queue_pixel({4'(hi), 4'(lo), 4'(hi), 4'(lo)}, mode, eff);
         end else begin
            queue_pixel({8'(hi), 8'(lo)}, mode, eff);
         end
         queue_pixel(16'h0000, mode, eff);
         queue_pixel(16'hFFFF, mode, eff);

         done = 0;
         while (done < PHASE_ITEMS[p]) begin
            queue_random(mode, eff, counts);
            if (counts)
               done++;
         end
         wait_drained();
      end
      no_stall = 1'b0;

      $display("covered %0d pixel words, %0d palette loads, %0d flag clears, %0d unused opcodes",
               pixels_sent, writes_sent, clears_sent, ignored_sent);
      $display("over %0d register settings; %0d texels compared, %0d mismatches",
               settings_used + 1, texels_checked, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
